FILE: rtl/calibration_map_region_checker_core_assert.svh
// Assertion macros for the calibration map region checker.
// Both forms sample on clk and are disabled while arst_n is low.
`ifndef CALIBRATION_MAP_REGION_CHECKER_CORE_ASSERT_SVH
`define CALIBRATION_MAP_REGION_CHECKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CMRC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmrc assertion failed");
`define CMRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmrc assertion failed");
`else
`define CMRC_ASSERT_SAME(label, ante, cons)
`define CMRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/cmrc_pkg.sv
`timescale 1ns / 1ps
package cmrc_pkg;

	localparam int IMAGE_BYTES  = 8192;
	localparam int REGION_COUNT = 8;
	localparam int REGION_W     = 3;
	localparam int ADDR_W       = 13;
	localparam int BYTE_W       = 8;
	localparam int CAT_W        = 6;
	localparam int DATA_W       = 24;
	localparam logic [BYTE_W-1:0] FLAG_OK = 8'h01;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [REGION_W-1:0] region_t;

	typedef enum logic [1:0] {
		ROLE_NONE,
		ROLE_SUM,
		ROLE_CSUM,
		ROLE_FLAG
	} role_t;

	localparam addr_t REGION_FIRST [REGION_COUNT] = '{
		13'h001, 13'h00D, 13'h01B, 13'h029, 13'h713, 13'hD37, 13'hD9F, 13'h100D};
	localparam addr_t REGION_FINAL [REGION_COUNT] = '{
		13'h007, 13'h012, 13'h026, 13'h710, 13'hA8C, 13'hD9C, 13'hDC4, 13'h180C};
	localparam addr_t REGION_CSUM [REGION_COUNT] = '{
		13'h009, 13'h013, 13'h027, 13'h711, 13'hA8D, 13'hD9D, 13'hDD5, 13'h180D};
	localparam addr_t REGION_FLAG [REGION_COUNT] = '{
		13'h000, 13'h00C, 13'h01A, 13'h028, 13'h712, 13'hD36, 13'hD9E, 13'h100C};

	typedef struct packed {
		role_t   role;
		region_t region;
	} dec_t;

	typedef struct packed {
		logic    vld;
		logic    last;
		role_t   role;
		region_t region;
		byte_t   value;
	} upd_t;

	typedef struct packed {
		logic                    vld;
		logic [REGION_COUNT-1:0] csum_fail;
		logic [REGION_COUNT-1:0] flag_fail;
	} res_t;

	// per-region failure to category: AF, AWB, LSC, PDAF (SPC|DCC), OIS, dual
	function automatic logic [CAT_W-1:0] category(input logic [REGION_COUNT-1:0] bad);
		logic [CAT_W-1:0] cat;
		cat[0] = bad[1];
		cat[1] = bad[2];
		cat[2] = bad[3];
		cat[3] = bad[4] | bad[5];
		cat[4] = bad[6];
		cat[5] = bad[7];
		return cat;
	endfunction

endpackage

FILE: rtl/calibration_map_region_checker_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: byte_address, byte_value; tlast: last_byte
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: checksum_fail, flag_fail, category_invalid
//
// One input word per cycle; each word does its region memory read-modify-write in stage s1.
// m_axis_tvalid rises once the last word has passed through upd_s1 and then the output register.
// Only a last word is held off: in the cycle its predecessor's result is formed, and while
// a result waits unread. Other words are taken every cycle.
// Reset clears the per-entry valid bits and status flops at once; no clearing pass.
// After each result all region state is dropped in the same cycle.
module calibration_map_region_checker_core
	import cmrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // [12:0] byte_address, [20:13] byte_value
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata   // [7:0] checksum_fail, [15:8] flag_fail,
	                                         // [21:16] category_invalid
);

	`include "calibration_map_region_checker_core_assert.svh"

	logic                    accept;
	dec_t                    dec;
	upd_t                    upd;
	res_t                    res;
	logic                    out_vld_q;
	logic [DATA_W-1:0]       out_data_q;
	logic [REGION_COUNT-1:0] bad;

	assign accept = s_axis_tvalid && s_axis_tready;

	cmrc_decode u_decode (
		.addr (s_axis_tdata[ADDR_W-1:0]),
		.dec  (dec)
	);

	assign upd.vld    = accept;
	assign upd.last   = s_axis_tlast;
	assign upd.role   = dec.role;
	assign upd.region = dec.region;
	assign upd.value  = s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W];

	cmrc_region_ram u_region_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.res    (res)
	);

	// only a last word needs the output register free next cycle
	assign s_axis_tready = !(s_axis_tlast && (res.vld || (out_vld_q && !m_axis_tready)));

	assign bad = res.csum_fail | res.flag_fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.vld) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			out_data_q <= {2'b00, category(bad), res.flag_fail, res.csum_fail};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	`CMRC_ASSERT_SAME(a_res_has_room, res.vld, !m_axis_tvalid || m_axis_tready)
	`CMRC_ASSERT_NEXT(a_last_gives_res, accept && s_axis_tlast, res.vld)
	`CMRC_ASSERT_SAME(a_pdaf_cat, m_axis_tvalid,
		m_axis_tdata[19] == (m_axis_tdata[4] | m_axis_tdata[5] | m_axis_tdata[12] |
			m_axis_tdata[13]))

endmodule

FILE: rtl/cmrc_decode.sv
`timescale 1ns / 1ps
module cmrc_decode
	import cmrc_pkg::*;
(
	input  addr_t addr,
	output dec_t  dec
);

	logic in_image;

	assign in_image = {19'd0, addr} < 32'(IMAGE_BYTES);

	// regions and their checksum/flag addresses never overlap: at most one hit
	always_comb begin
		dec.role   = ROLE_NONE;
		dec.region = '0;
		for (int r = 0; r < REGION_COUNT; r++) begin
			if (addr >= REGION_FIRST[r] && addr <= REGION_FINAL[r]) begin
				dec.role   = ROLE_SUM;
				dec.region = REGION_W'(r);
			end else if (addr == REGION_CSUM[r]) begin
				dec.role   = ROLE_CSUM;
				dec.region = REGION_W'(r);
			end else if (addr == REGION_FLAG[r]) begin
				dec.role   = ROLE_FLAG;
				dec.region = REGION_W'(r);
			end
		end
		if (!in_image) begin
			dec.role = ROLE_NONE;
		end
	end

endmodule

FILE: rtl/cmrc_region_ram.sv
`timescale 1ns / 1ps
module cmrc_region_ram
	import cmrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  upd_t upd,
	output res_t res
);

	typedef struct packed {
		byte_t sum;
		byte_t csum;
	} entry_t;

	entry_t mem [REGION_COUNT];

	upd_t   upd_s1;
	entry_t rd_data_s1;

	logic [REGION_COUNT-1:0] entry_vld_q;
	logic [REGION_COUNT-1:0] csum_mis_q;
	logic [REGION_COUNT-1:0] flag_ok_q;
	logic                    fwd_vld_q;
	region_t                 fwd_region_q;
	entry_t                  fwd_data_q;

	entry_t                  cur;
	entry_t                  nxt;
	logic                    wr_en;
	logic [REGION_COUNT-1:0] csum_mis_nxt;
	logic [REGION_COUNT-1:0] flag_ok_nxt;

	// read issued at accept, data lands with the word in s1
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[upd.region];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[upd_s1.region] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= '0;
		end else begin
			upd_s1 <= upd;
		end
	end

	// last cycle's write is not yet visible on the read port; invalid entries read as zero
	always_comb begin
		if (fwd_vld_q && fwd_region_q == upd_s1.region) begin
			cur = fwd_data_q;
		end else if (entry_vld_q[upd_s1.region]) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (upd_s1.role)
			ROLE_SUM:  nxt.sum  = cur.sum + upd_s1.value;
			ROLE_CSUM: nxt.csum = upd_s1.value;
			ROLE_FLAG,
			ROLE_NONE: nxt = cur;
			default:   nxt = cur;
		endcase
	end

	assign wr_en = upd_s1.vld && (upd_s1.role == ROLE_SUM || upd_s1.role == ROLE_CSUM);

	always_comb begin
		csum_mis_nxt = csum_mis_q;
		flag_ok_nxt  = flag_ok_q;
		if (wr_en) begin
			csum_mis_nxt[upd_s1.region] = nxt.sum != nxt.csum;
		end
		if (upd_s1.vld && upd_s1.role == ROLE_FLAG) begin
			flag_ok_nxt[upd_s1.region] = upd_s1.value == FLAG_OK;
		end
	end

	assign res.vld       = upd_s1.vld && upd_s1.last;
	assign res.csum_fail = csum_mis_nxt;
	assign res.flag_fail = ~flag_ok_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			csum_mis_q  <= '0;
			flag_ok_q   <= '0;
			fwd_vld_q   <= 1'b0;
		end else if (res.vld) begin
			// image done: drop every entry at once
			entry_vld_q <= '0;
			csum_mis_q  <= '0;
			flag_ok_q   <= '0;
			fwd_vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_vld_q[upd_s1.region] <= 1'b1;
			end
			csum_mis_q <= csum_mis_nxt;
			flag_ok_q  <= flag_ok_nxt;
			fwd_vld_q  <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_region_q <= upd_s1.region;
		fwd_data_q   <= nxt;
	end

endmodule

FILE: tb/calibration_map_region_checker_core_tb.sv
`timescale 1ns / 1ps
module calibration_map_region_checker_core_tb;
	import cmrc_pkg::*;

	// region slots and category bits, as the result masks order them
	localparam int RGN_MODULE = 0;
	localparam int RGN_AF     = 1;
	localparam int RGN_AWB    = 2;
	localparam int RGN_LSC    = 3;
	localparam int RGN_SPC    = 4;
	localparam int RGN_DCC    = 5;
	localparam int RGN_OIS    = 6;
	localparam int RGN_DUAL   = 7;

	localparam int CAT_AF   = 0;
	localparam int CAT_AWB  = 1;
	localparam int CAT_LSC  = 2;
	localparam int CAT_PDAF = 3;
	localparam int CAT_OIS  = 4;
	localparam int CAT_DUAL = 5;

	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_WORDS  = 530;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [REGION_COUNT-1:0] csum_bad;
		logic [REGION_COUNT-1:0] flag_bad;
		logic [CAT_W-1:0]        cat_bad;
	} verdict_t;

	typedef struct packed {
		addr_t addr;
		byte_t val;
		logic  last;
	} word_t;

	typedef struct packed {
		addr_t                   addr;
		byte_t                   val;
		logic                    last;
		logic                    typed;
		logic [REGION_COUNT-1:0] csum_bad;
		logic [REGION_COUNT-1:0] flag_bad;
		logic [CAT_W-1:0]        cat_bad;
	} row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		// straight out of reset: every flag unseen
		{13'h008, 8'h55, 1'b1, 1'b1, 8'h00, 8'hFF, 6'h3F},
		// all flags good, nothing summed, top address and top value
		{13'h000, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h00C, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h01A, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h028, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h712, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'hD36, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'hD9E, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h100C, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h1FFF, 8'hFF, 1'b1, 1'b1, 8'h00, 8'h00, 6'h00},
		// region edges, sums wrapping, OIS checksum at its odd address
		{13'h001, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h007, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h100D, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h180C, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'hDC4, 8'h12, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'hDD5, 8'h12, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'hD9E, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		// repeated flag address keeps the later value
		{13'h00C, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h00C, 8'h02, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h713, 8'h07, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h180D, 8'h01, 1'b1, 1'b0, 8'h00, 8'h00, 6'h00},
		// last mark on a flag byte
		{13'hD37, 8'hC3, 1'b0, 1'b0, 8'h00, 8'h00, 6'h00},
		{13'h000, 8'h01, 1'b1, 1'b0, 8'h00, 8'h00, 6'h00}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;  // [12:0] byte_address, [20:13] byte_value
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;       // [7:0] checksum_fail, [15:8] flag_fail,
	                                       // [21:16] category_invalid

	// typed expectation riding along with the offered word
	logic     offered_typed = 1'b0;
	verdict_t offered_want = '0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_req = 1'b0;
	int fail_count = 0;
	int stall_cycles = 0;

	// predictor state, mirrors one image in flight
	byte_t region_total [REGION_COUNT];
	byte_t region_csum  [REGION_COUNT];
	bit    region_flag_ok [REGION_COUNT];

	verdict_t pending_verdicts [$];
	word_t    image_words [$];

	calibration_map_region_checker_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void note_fail(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("MISMATCH: %s", msg);
		end
	endfunction

	function automatic void clear_image();
		for (int r = 0; r < REGION_COUNT; r++) begin
			region_total[r] = '0;
			region_csum[r] = '0;
			region_flag_ok[r] = 1'b0;
		end
	endfunction

	// take one byte into the image; on the last byte form the verdict and start over
	task automatic absorb_byte(input addr_t a, input byte_t v, input logic lst,
			output logic fired, output verdict_t res);
		logic [REGION_COUNT-1:0] bad;
		fired = 1'b0;
		res = '0;
		if (int'(a) < IMAGE_BYTES) begin
			for (int r = 0; r < REGION_COUNT; r++) begin
				if (a >= REGION_FIRST[r] && a <= REGION_FINAL[r]) begin
					region_total[r] = region_total[r] + v;
				end
				if (a == REGION_CSUM[r]) begin
					region_csum[r] = v;
				end
				if (a == REGION_FLAG[r]) begin
					region_flag_ok[r] = (v == FLAG_OK);
				end
			end
		end
		if (lst) begin
			for (int r = 0; r < REGION_COUNT; r++) begin
				res.csum_bad[r] = (region_total[r] != region_csum[r]);
				res.flag_bad[r] = !region_flag_ok[r];
			end
			bad = res.csum_bad | res.flag_bad;
			res.cat_bad[CAT_AF]   = bad[RGN_AF];
			res.cat_bad[CAT_AWB]  = bad[RGN_AWB];
			res.cat_bad[CAT_LSC]  = bad[RGN_LSC];
			res.cat_bad[CAT_PDAF] = bad[RGN_SPC] | bad[RGN_DCC];
			res.cat_bad[CAT_OIS]  = bad[RGN_OIS];
			res.cat_bad[CAT_DUAL] = bad[RGN_DUAL];
			fired = 1'b1;
			clear_image();
		end
	endtask

	// monitor: predicts on accepted input words, checks accepted result words
	always @(posedge clk) begin
		logic     fired;
		verdict_t guess;
		verdict_t seen;
		verdict_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_byte(addr_t'(s_axis_tdata[ADDR_W-1:0]),
					byte_t'(s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W]), s_axis_tlast, fired, guess);
				if (fired) begin
					pending_verdicts.push_back(offered_typed ? offered_want : guess);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen.csum_bad = m_axis_tdata[7:0];
				seen.flag_bad = m_axis_tdata[15:8];
				seen.cat_bad  = m_axis_tdata[21:16];
				if (pending_verdicts.size() == 0) begin
					note_fail($sformatf("result word %06h with none expected", m_axis_tdata));
				end else begin
					want = pending_verdicts.pop_front();
					if (seen.csum_bad !== want.csum_bad) begin
						note_fail($sformatf("checksum_fail expected %02h got %02h",
							want.csum_bad, seen.csum_bad));
					end
					if (seen.flag_bad !== want.flag_bad) begin
						note_fail($sformatf("flag_fail expected %02h got %02h",
							want.flag_bad, seen.flag_bad));
					end
					if (seen.cat_bad !== want.cat_bad) begin
						note_fail($sformatf("category_invalid expected %02h got %02h",
							want.cat_bad, seen.cat_bad));
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_word(input addr_t a, input byte_t v, input logic lst,
			input logic typed, input verdict_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DATA_W'({v, a});
		s_axis_tlast <= lst;
		offered_typed <= typed;
		offered_want <= want;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic push_stray();
		word_t w;
		w.addr = addr_t'($urandom);
		w.val = byte_t'($urandom);
		w.last = 1'b0;
		image_words.push_back(w);
	endtask

	// mostly well-formed images with random content, some pure noise
	task automatic build_image();
		int    kind;
		int    n;
		int    j;
		byte_t total;
		word_t w;
		word_t tmp;
		image_words.delete();
		kind = $urandom_range(9);
		w.last = 1'b0;
		if (kind == 0) begin
			n = $urandom_range(20, 1);
			repeat (n) push_stray();
		end else begin
			for (int r = 0; r < REGION_COUNT; r++) begin
				if ($urandom_range(3) != 0) begin
					total = '0;
					n = $urandom_range(4);
					repeat (n) begin
						w.addr = addr_t'($urandom_range(int'(REGION_FINAL[r]),
							int'(REGION_FIRST[r])));
						w.val = byte_t'($urandom);
						total = total + w.val;
						image_words.push_back(w);
					end
					w.addr = REGION_FLAG[r];
					w.val = ($urandom_range(9) != 0) ? FLAG_OK : byte_t'($urandom);
					image_words.push_back(w);
					if ($urandom_range(19) != 0) begin
						w.addr = REGION_CSUM[r];
						w.val = ($urandom_range(9) != 0) ? total : byte_t'($urandom);
						image_words.push_back(w);
					end
				end
			end
			n = $urandom_range(3);
			repeat (n) push_stray();
			if (kind == 9 && image_words.size() != 0) begin
				image_words.push_back(image_words[$urandom_range(image_words.size() - 1)]);
			end
			for (int i = image_words.size() - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = image_words[i];
				image_words[i] = image_words[j];
				image_words[j] = tmp;
			end
		end
		if (image_words.size() == 0) begin
			push_stray();
		end
		image_words[image_words.size() - 1].last = 1'b1;
	endtask

	initial begin
		int       sent;
		bit       hold_done;
		verdict_t want;
		hold_done = 1'b0;
		clear_image();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 7;
					rx_idle_pct = 56;
				end
				1: begin
					tx_idle_pct = 56;
					rx_idle_pct = 7;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				for (int i = 0; i < DIRECTED_ROWS; i++) begin
					want.csum_bad = DIRECTED[i].csum_bad;
					want.flag_bad = DIRECTED[i].flag_bad;
					want.cat_bad = DIRECTED[i].cat_bad;
					send_word(DIRECTED[i].addr, DIRECTED[i].val, DIRECTED[i].last,
						DIRECTED[i].typed, want);
				end
			end
			sent = 0;
			while (sent < PHASE_WORDS) begin
				// long result-side stall while words keep coming
				if (phase == 0 && !hold_done && sent >= 100) begin
					hold_req = 1'b1;
					hold_done = 1'b1;
				end
				build_image();
				foreach (image_words[i]) begin
					send_word(image_words[i].addr, image_words[i].val, image_words[i].last,
						1'b0, '0);
					sent++;
				end
			end
			drain_results();
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_verdicts.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
